### hw/rtl/sgrp_pkg.sv
package sgrp_pkg;

	// Stream characters
	localparam logic [7:0] ESC_BYTE  = 8'd27;
	localparam logic [7:0] CHAR_LBR  = 8'h5B;  // '['
	localparam logic [7:0] CHAR_SEMI = 8'h3B;  // ';'
	localparam logic [7:0] CHAR_M    = 8'h6D;  // 'm'
	localparam logic [7:0] CHAR_0    = 8'h30;  // '0'
	localparam logic [7:0] CHAR_9    = 8'h39;  // '9'

	localparam logic [9:0] PARAM_MAX = 10'd1023;
	localparam logic [9:0] INDEX_MAX = 10'd255;

	// SGR parameter codes
	localparam logic [9:0] CODE_RESET     = 10'd0;
	localparam logic [9:0] CODE_BOLD      = 10'd1;
	localparam logic [9:0] CODE_UNDERLINE = 10'd4;
	localparam logic [9:0] CODE_FG_BASE   = 10'd30;
	localparam logic [9:0] CODE_FG_LAST   = 10'd37;
	localparam logic [9:0] CODE_FG_EXT    = 10'd38;
	localparam logic [9:0] CODE_BG_BASE   = 10'd40;
	localparam logic [9:0] CODE_BG_LAST   = 10'd47;
	localparam logic [9:0] CODE_BG_EXT    = 10'd48;
	localparam logic [9:0] CODE_EXT_SEL   = 10'd5;

	// Queue depths
	localparam int OP_DEPTH  = 4;
	localparam int RES_DEPTH = 4;

	typedef enum logic [1:0] {
		PH_TEXT,
		PH_ESC,
		PH_PARAM
	} phase_t;

	typedef enum logic [1:0] {
		EXT_NONE,
		EXT_WAIT_SEL,
		EXT_WAIT_INDEX
	} ext_t;

	typedef enum logic [1:0] {
		OP_TEXT,      // emit value[7:0] as one glyph
		OP_ESC_PAIR,  // emit ESC, then value[7:0]
		OP_PLAIN,     // apply plain SGR code in value
		OP_EXT        // apply extended palette index in value
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic       ext_bg;
		logic [9:0] value;
	} op_t;

	typedef struct packed {
		logic [7:0] glyph;
		logic       fg_caller;
		logic [7:0] fg_index;
		logic       bg_on;
		logic [7:0] bg_index;
		logic       underline_on;
		logic       bold_on;
		logic       last_out;
	} res_t;

endpackage

### hw/rtl/sgrp_fifo.sv
module sgrp_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/sgrp_front.sv
module sgrp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    in_byte,
	output logic          op_valid,
	output sgrp_pkg::op_t op
);

	import sgrp_pkg::*;

	phase_t     phase_q, phase_d;
	ext_t       ext_q, ext_d;
	logic       ext_bg_q, ext_bg_d;
	logic [9:0] pv_q, pv_d;

	logic [3:0]  digit;
	logic [13:0] pv_next;
	logic [9:0]  pv_sat;
	logic        is_digit;

	assign is_digit = (in_byte >= CHAR_0) && (in_byte <= CHAR_9);
	assign digit    = 4'(in_byte - CHAR_0);
	assign pv_next  = ({4'b0, pv_q} << 3) + ({4'b0, pv_q} << 1) + {10'b0, digit};
	assign pv_sat   = (pv_next > {4'b0, PARAM_MAX}) ? PARAM_MAX : pv_next[9:0];

	always_comb begin
		phase_d   = phase_q;
		ext_d     = ext_q;
		ext_bg_d  = ext_bg_q;
		pv_d      = pv_q;
		op_valid  = 1'b0;
		op.kind   = OP_TEXT;
		op.ext_bg = ext_bg_q;
		op.value  = {2'b0, in_byte};

		unique case (phase_q)
			PH_TEXT: begin
				if (in_byte == ESC_BYTE) begin
					phase_d = PH_ESC;
				end else begin
					op_valid = 1'b1;
				end
			end
			PH_ESC: begin
				priority if (in_byte == CHAR_LBR) begin
					phase_d  = PH_PARAM;
					pv_d     = '0;
					ext_d    = EXT_NONE;
					ext_bg_d = 1'b0;
				end else if (in_byte == ESC_BYTE) begin
					op_valid = 1'b1;
				end else begin
					op_valid = 1'b1;
					op.kind  = OP_ESC_PAIR;
					phase_d  = PH_TEXT;
				end
			end
			PH_PARAM: begin
				priority if (is_digit) begin
					pv_d = pv_sat;
				end else if (in_byte == CHAR_SEMI || in_byte == CHAR_M) begin
					pv_d     = '0;
					op.value = pv_q;
					// resolve the parameter against the pending extended form
					priority if (ext_q == EXT_WAIT_SEL && pv_q == CODE_EXT_SEL) begin
						ext_d = EXT_WAIT_INDEX;
					end else if (ext_q == EXT_WAIT_INDEX) begin
						ext_d    = EXT_NONE;
						op_valid = 1'b1;
						op.kind  = OP_EXT;
						op.value = (pv_q > INDEX_MAX) ? INDEX_MAX : pv_q;
					end else if (pv_q == CODE_FG_EXT || pv_q == CODE_BG_EXT) begin
						ext_d    = EXT_WAIT_SEL;
						ext_bg_d = (pv_q == CODE_BG_EXT);
					end else begin
						ext_d    = EXT_NONE;
						op_valid = 1'b1;
						op.kind  = OP_PLAIN;
					end
					if (in_byte == CHAR_M) begin
						phase_d  = PH_TEXT;
						ext_d    = EXT_NONE;
						ext_bg_d = 1'b0;
					end
				end else begin
					// abandon the open sequence unapplied
					pv_d     = '0;
					ext_d    = EXT_NONE;
					ext_bg_d = 1'b0;
					phase_d  = (in_byte == ESC_BYTE) ? PH_ESC : PH_TEXT;
				end
			end
			default: begin
				phase_d = PH_TEXT;
			end
		endcase

		if (!accept) begin
			op_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TEXT;
			ext_q    <= EXT_NONE;
			ext_bg_q <= 1'b0;
			pv_q     <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			ext_q    <= ext_d;
			ext_bg_q <= ext_bg_d;
			pv_q     <= pv_d;
		end
	end

endmodule

### hw/rtl/sgrp_back.sv
module sgrp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  sgrp_pkg::op_t  head,
	input  logic           op_empty,
	output logic           op_pop,
	input  logic           res_full,
	output logic           res_push,
	output sgrp_pkg::res_t res
);

	import sgrp_pkg::*;

	logic       half_q;
	logic       fg_caller_q;
	logic       base_caller_q;
	logic [7:0] fg_index_q;
	logic [7:0] bg_index_q;
	logic       bg_on_q;
	logic       underline_q;
	logic       bold_q;

	logic       half_d;
	logic       fg_caller_d;
	logic       base_caller_d;
	logic [7:0] fg_index_d;
	logic [7:0] bg_index_d;
	logic       bg_on_d;
	logic       underline_d;
	logic       bold_d;

	logic needs_out;
	logic first_of_pair;

	assign needs_out     = (head.kind == OP_TEXT) || (head.kind == OP_ESC_PAIR);
	assign first_of_pair = (head.kind == OP_ESC_PAIR) && !half_q;
	assign res_push      = !op_empty && needs_out && !res_full;
	assign op_pop        = !op_empty && (!needs_out || (!res_full && !first_of_pair));

	always_comb begin
		res.glyph        = first_of_pair ? ESC_BYTE : head.value[7:0];
		res.fg_caller    = fg_caller_q;
		res.fg_index     = fg_caller_q ? 8'd0 : fg_index_q;
		res.bg_on        = bg_on_q;
		res.bg_index     = bg_on_q ? bg_index_q : 8'd0;
		res.underline_on = underline_q;
		res.bold_on      = bold_q;
		res.last_out     = !first_of_pair;
	end

	always_comb begin
		half_d        = half_q;
		fg_caller_d   = fg_caller_q;
		base_caller_d = base_caller_q;
		fg_index_d    = fg_index_q;
		bg_index_d    = bg_index_q;
		bg_on_d       = bg_on_q;
		underline_d   = underline_q;
		bold_d        = bold_q;

		if (res_push && head.kind == OP_ESC_PAIR) begin
			half_d = !half_q;
		end

		if (op_pop) begin
			unique case (head.kind)
				OP_TEXT, OP_ESC_PAIR: begin
				end
				OP_EXT: begin
					if (head.ext_bg) begin
						bg_on_d    = 1'b1;
						bg_index_d = head.value[7:0];
					end else begin
						fg_caller_d = 1'b0;
						fg_index_d  = head.value[7:0];
					end
				end
				OP_PLAIN: begin
					priority if (head.value > CODE_FG_BASE && head.value <= CODE_FG_LAST) begin
						fg_caller_d = 1'b0;
						fg_index_d  = 8'(head.value - CODE_FG_BASE);
					end else if (head.value > CODE_BG_BASE && head.value <= CODE_BG_LAST) begin
						bg_on_d    = 1'b1;
						bg_index_d = 8'(head.value - CODE_BG_BASE);
					end else if (head.value == CODE_RESET) begin
						base_caller_d = 1'b0;
						fg_caller_d   = 1'b0;
						fg_index_d    = 8'd0;
						underline_d   = 1'b0;
						bg_on_d       = 1'b0;
						bold_d        = 1'b0;
					end else if (head.value == CODE_BOLD) begin
						bold_d = 1'b1;
					end else if (head.value == CODE_UNDERLINE) begin
						underline_d = 1'b1;
					end else if (head.value == CODE_FG_BASE) begin
						fg_caller_d = base_caller_q;
						fg_index_d  = 8'd0;
					end else if (head.value == CODE_BG_BASE) begin
						bg_on_d = 1'b0;
					end else begin
						// unhandled code: drop
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q        <= 1'b0;
			fg_caller_q   <= 1'b1;
			base_caller_q <= 1'b1;
			fg_index_q    <= '0;
			bg_index_q    <= '0;
			bg_on_q       <= 1'b0;
			underline_q   <= 1'b0;
			bold_q        <= 1'b0;
		end else begin
			half_q        <= half_d;
			fg_caller_q   <= fg_caller_d;
			base_caller_q <= base_caller_d;
			fg_index_q    <= fg_index_d;
			bg_index_q    <= bg_index_d;
			bg_on_q       <= bg_on_d;
			underline_q   <= underline_d;
			bold_q        <= bold_d;
		end
	end

	// second half of a pair only ever waits on a pair op at the head
	a_half_head: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> (!op_empty && head.kind == OP_ESC_PAIR))
		else $error("pair half pending without pair op at head");

	// a non-final beat is always the leading ESC of a pair
	a_nonlast_esc: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !res.last_out) |-> (res.glyph == ESC_BYTE))
		else $error("non-final result is not ESC");

	// after the leading ESC beat, the pair waits on its second half
	a_pair_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !res.last_out) |=> half_q)
		else $error("pair did not advance to its second half");

	// the pair op leaves the queue only with its final beat
	a_pair_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(op_pop && head.kind == OP_ESC_PAIR) |-> (half_q && res_push))
		else $error("pair op dropped before its second beat");

endmodule

### hw/rtl/ansi_sgr_attribute_parser_core.sv
// Path: an accepted text byte is written into the op queue, then into the
// result queue, and then shows on the result ports (empty low); a byte that
// only updates state gives none.
// Throughput: one byte per cycle while the op queue has room; a lone ESC
// followed by text yields two result beats from the back end.
// Reset: arst_n clears both queues, the parser to plain text and the
// attributes to caller colour, no background, no underline, normal weight.
module ansi_sgr_attribute_parser_core #(
	parameter int OP_DEPTH  = sgrp_pkg::OP_DEPTH,
	parameter int RES_DEPTH = sgrp_pkg::RES_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// input queue side
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	// result queue side
	output logic       empty,
	input  logic       pop,
	output logic [7:0] glyph,
	output logic       fg_caller,
	output logic [7:0] fg_index,
	output logic       bg_on,
	output logic [7:0] bg_index,
	output logic       underline_on,
	output logic       bold_on,
	output logic       last_out
);

	import sgrp_pkg::*;

	localparam int OP_W  = $bits(op_t);
	localparam int RES_W = $bits(res_t);

	logic            accept;
	logic            op_valid;
	op_t             op_in;
	logic [OP_W-1:0] op_rd_data;
	op_t             op_head;
	logic            op_empty;
	logic            op_full;
	logic            op_pop;

	logic             res_push;
	logic             res_full;
	res_t             res_in;
	logic [RES_W-1:0] res_rd_data;
	res_t             res_out;

	// Take a beat whenever the op queue has room; bytes that produce no op
	// are taken too, so the front only stalls on a full op queue.
	assign full   = op_full;
	assign accept = push && !op_full;

	// Front end: parse the byte stream and classify each byte into an op.
	sgrp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.op_valid (op_valid),
		.op       (op_in)
	);

	// Decoupling queue between the parser and the attribute engine.
	sgrp_fifo #(
		.WIDTH (OP_W),
		.DEPTH (OP_DEPTH)
	) u_op_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (op_valid),
		.wr_data (op_in),
		.full    (op_full),
		.rd_en   (op_pop),
		.rd_data (op_rd_data),
		.empty   (op_empty)
	);

	assign op_head = op_t'(op_rd_data);

	// Back end: hold the attributes, apply SGR ops, tag glyphs.
	sgrp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (op_head),
		.op_empty (op_empty),
		.op_pop   (op_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	// Result queue: lets the back end run while the consumer stalls.
	sgrp_fifo #(
		.WIDTH (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_rd_data),
		.empty   (empty)
	);

	assign res_out      = res_t'(res_rd_data);
	assign glyph        = res_out.glyph;
	assign fg_caller    = res_out.fg_caller;
	assign fg_index     = res_out.fg_index;
	assign bg_on        = res_out.bg_on;
	assign bg_index     = res_out.bg_index;
	assign underline_on = res_out.underline_on;
	assign bold_on      = res_out.bold_on;
	assign last_out     = res_out.last_out;

endmodule

### tb/ansi_sgr_attribute_parser_core_checker.sv
`timescale 1ns / 1ps

module ansi_sgr_attribute_parser_core_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] in_byte,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] glyph,
	input  logic       fg_caller,
	input  logic [7:0] fg_index,
	input  logic       bg_on,
	input  logic [7:0] bg_index,
	input  logic       underline_on,
	input  logic       bold_on,
	input  logic       last_out,
	output int         err_count,
	output int         outstanding,
	output int         bytes_seen,
	output int         beats_checked
);

	import sgrp_pkg::*;

	// parser and attribute state, mirrored from the stream
	phase_t     scan_mode;
	logic [9:0] param_acc;
	ext_t       ext_state;
	logic       ext_is_bg;
	logic       attr_fg_caller;
	logic       attr_dflt_caller;
	logic [7:0] attr_fg_idx;
	logic [7:0] attr_bg_idx;
	logic       attr_bg_on;
	logic       attr_ul;
	logic       attr_bold;

	res_t tagged_glyphs[$];
	int   n_err = 0;
	int   n_in  = 0;
	int   n_out = 0;

	function automatic void open_sequence();
		param_acc = '0;
		ext_state = EXT_NONE;
		ext_is_bg = 1'b0;
	endfunction

	function automatic void queue_glyph(logic [7:0] ch, logic last);
		res_t r;
		r.glyph        = ch;
		r.fg_caller    = attr_fg_caller;
		r.fg_index     = attr_fg_caller ? 8'd0 : attr_fg_idx;
		r.bg_on        = attr_bg_on;
		r.bg_index     = attr_bg_on ? attr_bg_idx : 8'd0;
		r.underline_on = attr_ul;
		r.bold_on      = attr_bold;
		r.last_out     = last;
		tagged_glyphs.insert(tagged_glyphs.size(), r);
	endfunction

	function automatic void apply_code(logic [9:0] v);
		if (v > CODE_FG_BASE && v <= CODE_FG_LAST) begin
			attr_fg_caller = 1'b0;
			attr_fg_idx    = 8'(v - CODE_FG_BASE);
		end else if (v > CODE_BG_BASE && v <= CODE_BG_LAST) begin
			attr_bg_on  = 1'b1;
			attr_bg_idx = 8'(v - CODE_BG_BASE);
		end else if (v == CODE_RESET) begin
			// palette 0 becomes the default from here on
			attr_dflt_caller = 1'b0;
			attr_fg_caller   = 1'b0;
			attr_fg_idx      = '0;
			attr_ul          = 1'b0;
			attr_bg_on       = 1'b0;
			attr_bold        = 1'b0;
		end else if (v == CODE_BOLD) begin
			attr_bold = 1'b1;
		end else if (v == CODE_UNDERLINE) begin
			attr_ul = 1'b1;
		end else if (v == CODE_FG_BASE) begin
			attr_fg_caller = attr_dflt_caller;
			attr_fg_idx    = '0;
		end else if (v == CODE_FG_EXT || v == CODE_BG_EXT) begin
			ext_state = EXT_WAIT_SEL;
			ext_is_bg = (v == CODE_BG_EXT);
		end else if (v == CODE_BG_BASE) begin
			attr_bg_on = 1'b0;
		end
	endfunction

	function automatic void apply_param(logic [9:0] v);
		logic [7:0] idx;
		idx = (v > INDEX_MAX) ? 8'hFF : v[7:0];
		if (ext_state == EXT_WAIT_SEL) begin
			// anything but 5 drops the extended form and counts as a plain code
			if (v == CODE_EXT_SEL) begin
				ext_state = EXT_WAIT_INDEX;
			end else begin
				ext_state = EXT_NONE;
				apply_code(v);
			end
		end else if (ext_state == EXT_WAIT_INDEX) begin
			ext_state = EXT_NONE;
			if (ext_is_bg) begin
				attr_bg_on  = 1'b1;
				attr_bg_idx = idx;
			end else begin
				attr_fg_caller = 1'b0;
				attr_fg_idx    = idx;
			end
		end else begin
			apply_code(v);
		end
	endfunction

	function automatic void take_byte(logic [7:0] b);
		int unsigned nv;
		case (scan_mode)
			PH_ESC: begin
				if (b == CHAR_LBR) begin
					scan_mode = PH_PARAM;
					open_sequence();
				end else if (b == ESC_BYTE) begin
					queue_glyph(ESC_BYTE, 1'b1);
				end else begin
					scan_mode = PH_TEXT;
					queue_glyph(ESC_BYTE, 1'b0);
					queue_glyph(b, 1'b1);
				end
			end
			PH_PARAM: begin
				if (b >= CHAR_0 && b <= CHAR_9) begin
					nv        = param_acc * 10 + (b - CHAR_0);
					param_acc = (nv > PARAM_MAX) ? PARAM_MAX : nv[9:0];
				end else if (b == CHAR_SEMI) begin
					apply_param(param_acc);
					param_acc = '0;
				end else if (b == CHAR_M) begin
					apply_param(param_acc);
					open_sequence();
					scan_mode = PH_TEXT;
				end else if (b == ESC_BYTE) begin
					open_sequence();
					scan_mode = PH_ESC;
				end else begin
					open_sequence();
					scan_mode = PH_TEXT;
				end
			end
			default: begin
				if (b == ESC_BYTE) scan_mode = PH_ESC;
				else queue_glyph(b, 1'b1);
			end
		endcase
	endfunction

	function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
		if (want != got) begin
			n_err++;
			$error("%s: expected %0d, got %0d", field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			scan_mode        = PH_TEXT;
			open_sequence();
			attr_fg_caller   = 1'b1;
			attr_dflt_caller = 1'b1;
			attr_fg_idx      = '0;
			attr_bg_idx      = '0;
			attr_bg_on       = 1'b0;
			attr_ul          = 1'b0;
			attr_bold        = 1'b0;
			tagged_glyphs.delete();
		end else begin
			if (push && !full) begin
				take_byte(in_byte);
				n_in++;
			end
			if (pop && !empty) begin
				n_out++;
				if (tagged_glyphs.size() == 0) begin
					n_err++;
					$error("result beat with nothing expected: glyph %0d", glyph);
				end else begin
					want = tagged_glyphs.pop_front();
					check_field("glyph", want.glyph, glyph);
					check_field("fg_caller", 8'(want.fg_caller), 8'(fg_caller));
					check_field("fg_index", want.fg_index, fg_index);
					check_field("bg_on", 8'(want.bg_on), 8'(bg_on));
					check_field("bg_index", want.bg_index, bg_index);
					check_field("underline_on", 8'(want.underline_on), 8'(underline_on));
					check_field("bold_on", 8'(want.bold_on), 8'(bold_on));
					check_field("last_out", 8'(want.last_out), 8'(last_out));
				end
			end
		end
		err_count     <= n_err;
		outstanding   <= tagged_glyphs.size();
		bytes_seen    <= n_in;
		beats_checked <= n_out;
	end

endmodule

### tb/ansi_sgr_attribute_parser_core_tb.sv
`timescale 1ns / 1ps

module ansi_sgr_attribute_parser_core_tb;
	import sgrp_pkg::*;

	logic       clk     = 1'b0;
	logic       arst_n  = 1'b0;
	logic       push    = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       pop     = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] glyph;
	logic       fg_caller;
	logic [7:0] fg_index;
	logic       bg_on;
	logic [7:0] bg_index;
	logic       underline_on;
	logic       bold_on;
	logic       last_out;

	int err_count;
	int outstanding;
	int bytes_seen;
	int beats_checked;

	// idle rates in percent, changed once per flow-control phase
	int tx_idle_pct = 34;
	int rx_idle_pct = 76;
	int sent        = 0;

	ansi_sgr_attribute_parser_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_byte     (in_byte),
		.empty       (empty),
		.pop         (pop),
		.glyph       (glyph),
		.fg_caller   (fg_caller),
		.fg_index    (fg_index),
		.bg_on       (bg_on),
		.bg_index    (bg_index),
		.underline_on(underline_on),
		.bold_on     (bold_on),
		.last_out    (last_out)
	);

	ansi_sgr_attribute_parser_core_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.in_byte      (in_byte),
		.empty        (empty),
		.pop          (pop),
		.glyph        (glyph),
		.fg_caller    (fg_caller),
		.fg_index     (fg_index),
		.bg_on        (bg_on),
		.bg_index     (bg_index),
		.underline_on (underline_on),
		.bold_on      (bold_on),
		.last_out     (last_out),
		.err_count    (err_count),
		.outstanding  (outstanding),
		.bytes_seen   (bytes_seen),
		.beats_checked(beats_checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stall the result side at the current rate; decide afresh every cycle.
	always @(posedge clk) begin
		pop <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Hand one byte to the block. Idle first at the sender's rate, then hold
	// push high until a beat is taken. Push is left high on return: the caller
	// either drives the next byte in the same step or lowers it.
	task automatic push_byte(logic [7:0] b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (full);
		sent++;
	endtask

	// Write a decimal parameter, now and then with a leading zero.
	task automatic push_number(int v);
		string s;
		s = $sformatf("%0d", v);
		if ($urandom_range(0, 7) == 0) push_byte(CHAR_0);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endtask

	// One parameter slot of a well-formed sequence.
	task automatic push_param();
		int v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 2))
					0: v = int'(CODE_RESET);
					1: v = int'(CODE_BOLD);
					default: v = int'(CODE_UNDERLINE);
				endcase
				push_number(v);
			end
			1, 2: push_number(int'($urandom_range(CODE_FG_BASE, CODE_FG_LAST)));
			3, 4: push_number(int'($urandom_range(CODE_BG_BASE, CODE_BG_LAST)));
			5, 6: begin
				// extended palette form, sometimes with a wrong selector
				push_number($urandom_range(0, 1) ? int'(CODE_FG_EXT) : int'(CODE_BG_EXT));
				push_byte(CHAR_SEMI);
				push_number($urandom_range(0, 4) ? int'(CODE_EXT_SEL)
					: int'($urandom_range(0, 49)));
				push_byte(CHAR_SEMI);
				push_number($urandom_range(0, 5) ? int'($urandom_range(0, 255))
					: int'($urandom_range(256, 1023)));
			end
			7: push_number($urandom_range(0, 3) ? int'($urandom_range(0, 99))
				: int'($urandom_range(0, 1023)));
			8: begin
				// long run of digits, can saturate the accumulator
				repeat ($urandom_range(4, 6)) push_byte(8'(CHAR_0 + $urandom_range(0, 9)));
			end
			default: ;  // empty parameter
		endcase
	endtask

	task automatic push_text();
		repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
	endtask

	// One random chunk: mostly well-formed sequences followed by text,
	// the rest plain text, broken sequences and byte noise.
	task automatic push_chunk();
		int         r;
		logic [7:0] t;
		r = int'($urandom_range(0, 99));
		if (r < 55) begin
			push_byte(ESC_BYTE);
			push_byte(CHAR_LBR);
			repeat ($urandom_range(0, 3)) begin
				push_param();
				push_byte(CHAR_SEMI);
			end
			push_param();
			push_byte(CHAR_M);
			push_text();
		end else if (r < 75) begin
			push_text();
		end else if (r < 88) begin
			push_byte(ESC_BYTE);
			push_byte(CHAR_LBR);
			push_param();
			if ($urandom_range(0, 1)) begin
				push_byte(CHAR_SEMI);
				push_param();
			end
			if ($urandom_range(0, 2) == 0) begin
				push_byte(ESC_BYTE);
			end else begin
				do t = 8'($urandom_range(0, 255));
				while ((t >= CHAR_0 && t <= CHAR_9) || t == CHAR_SEMI || t == CHAR_M);
				push_byte(t);
			end
		end else begin
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(0, 5))
					0: push_byte(ESC_BYTE);
					1: push_byte(CHAR_LBR);
					2: push_byte(CHAR_SEMI);
					3: push_byte(CHAR_M);
					4: push_byte(8'(CHAR_0 + $urandom_range(0, 9)));
					default: push_byte(8'($urandom_range(0, 255)));
				endcase
			end
		end
	endtask

	initial begin
		logic [7:0] opening[$];
		int         tx_tab[3];
		int         rx_tab[3];
		int         guard;

		tx_tab = '{34, 76, 0};
		rx_tab = '{76, 34, 0};

		// Directed opening:
		// - byte extremes and a lone ESC before text
		// - 38 without 5 (dropped, 1 taken as bold), 30 back to caller colour
		// - ESC ESC, empty parameter as reset, 48;5 index saturating,
		//   sequence ending while an extended form waits
		// - ESC inside parameters, then an unknown byte abandoning the sequence
		opening = '{8'h00, 8'hFF, ESC_BYTE, "A",
			ESC_BYTE, CHAR_LBR, "3", "8", CHAR_SEMI, "1", CHAR_SEMI, "3", "0", CHAR_M,
			ESC_BYTE, ESC_BYTE, CHAR_LBR, CHAR_SEMI, "4", "8", CHAR_SEMI, "5", CHAR_SEMI,
			"9", "9", "9", "9", CHAR_SEMI, "3", "8", CHAR_M,
			ESC_BYTE, CHAR_LBR, "4", ESC_BYTE, CHAR_LBR, "4", "x", "w"};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = tx_tab[ph];
			rx_idle_pct = rx_tab[ph];
			if (ph == 0) foreach (opening[i]) push_byte(opening[i]);
			while (sent < (ph + 1) * 350) push_chunk();
			// Hold the sender until every expected beat has drained.
			push <= 1'b0;
			do @(posedge clk); while (outstanding != 0);
		end

		// Let any stray beat show up before judging.
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (outstanding != 0 && guard < 5000);
		repeat (8) @(posedge clk);

		$display("Summary: %0d stream bytes pushed over three flow-control phases,", bytes_seen);
		$display("  %0d tagged glyph beats compared field by field", beats_checked);
		if (err_count == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
